/* rtl/core/ilid_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the indexed list block.
package ilid_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 16;
    localparam int OP_W         = 3;
    localparam int LEN_W        = 9;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD,
        S_WR,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic              accepted;
        logic              full_drop;
        logic [LEN_W-1:0]  list_length;
    } res_t;

endpackage

/* rtl/core/ilid_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ilid_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: decodes a request, walks the shift pointer and keeps the count.
module ilid_ctrl #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ilid_pkg::OP_W-1:0]    operation,
    input  logic [ilid_pkg::IDX_W-1:0]   index,
    input  logic [ilid_pkg::DATA_W-1:0]  value,
    output ilid_pkg::res_t               res,
    output logic                         res_valid,
    input  logic                         res_take,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [ilid_pkg::DATA_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [ilid_pkg::DATA_W-1:0]  ram_rdata
);

    import ilid_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic               dir_reg, dir_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  rv_reg, rv_next;
    logic               found_reg, found_next;
    logic               acc_reg, acc_next;
    logic               drop_reg, drop_next;

    logic [AW-1:0]      ptr_step;
    logic [IDX_W-1:0]   cnt16;
    logic [IDX_W-1:0]   idx_mag;
    logic               idx_neg;
    logic               in_range;
    logic               full;
    logic               ins_ok;
    logic [IDX_W-1:0]   ins_pos;
    logic [CNT_W-1:0]   cnt_m2;
    logic [CNT_W+LEN_W-1:0] len_ext;

    // single shared pointer adder, +1 for delete, -1 for insert
    assign ptr_step = ptr_reg + (dir_reg ? AW'(1) : {AW{1'b1}});

    assign cnt16    = IDX_W'(count_reg);
    assign idx_neg  = index[IDX_W-1];
    assign idx_mag  = {1'b0, index[IDX_W-2:0]};
    assign in_range = !idx_neg && (idx_mag < cnt16);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign len_ext  = {{LEN_W{1'b0}}, count_reg};

    always_comb
    begin
        ins_ok  = 1'b1;
        ins_pos = '0;
        case (operation)
            OP_BACK:
            begin
                ins_pos = cnt16;
            end
            OP_AT:
            begin
                if (!idx_neg && (idx_mag > cnt16))
                begin
                    ins_ok = 1'b0;
                end
                else if (!idx_neg)
                begin
                    ins_pos = idx_mag;
                end
            end
            default:
            begin
                ins_pos = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        last_reg  <= last_next;
        pos_reg   <= pos_next;
        dir_reg   <= dir_next;
        val_reg   <= val_next;
        rv_reg    <= rv_next;
        found_reg <= found_next;
        acc_reg   <= acc_next;
        drop_reg  <= drop_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        val_next   = val_reg;
        rv_next    = rv_reg;
        found_next = found_reg;
        acc_next   = acc_reg;
        drop_next  = drop_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = ptr_step;
        in_stall   = 1'b1;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    rv_next    = '0;
                    found_next = 1'b0;
                    acc_next   = 1'b0;
                    drop_next  = 1'b0;
                    state_next = S_DONE;
                    val_next   = value;
                    unique case (operation)
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = index[AW-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                rv_next = '1;
                            end
                        end
                        OP_FRONT, OP_BACK, OP_AT:
                        begin
                            if (ins_ok && full)
                            begin
                                drop_next = 1'b1;
                            end
                            else if (ins_ok && (ins_pos == cnt16))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ins_pos[AW-1:0];
                                ram_wdata  = value;
                                count_next = count_reg + CNT_W'(1);
                                acc_next   = 1'b1;
                            end
                            else if (ins_ok)
                            begin
                                ptr_next   = count_reg[AW-1:0];
                                pos_next   = ins_pos[AW-1:0];
                                last_next  = ins_pos[AW-1:0] + AW'(1);
                                dir_next   = 1'b0;
                                state_next = S_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_range && (idx_mag == cnt16 - IDX_W'(1)))
                            begin
                                count_next = count_reg - CNT_W'(1);
                                acc_next   = 1'b1;
                            end
                            else if (in_range)
                            begin
                                ptr_next   = index[AW-1:0];
                                last_next  = cnt_m2[AW-1:0];
                                dir_next   = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rv_next    = ram_rdata;
                found_next = 1'b1;
                state_next = S_DONE;
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_step;
                if (ptr_reg == last_reg)
                begin
                    if (dir_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        acc_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                acc_next   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.read_value  = rv_reg;
        res.found       = found_reg;
        res.accepted    = acc_reg;
        res.full_drop   = drop_reg;
        res.list_length = len_ext[LEN_W-1:0];
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(ram_re))
        else $error("read data used without a read");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_take) |=> (state_reg == S_DONE && $stable(res)))
        else $error("pending result lost");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> ($past(state_reg) == S_RD))
        else $error("shift write without read");
`endif

endmodule

/* rtl/core/indexed_list_insert_delete.sv */
`timescale 1ns / 1ps
// Indexed list: ordered store of signed words with read, insert and delete by position.
// Usage:
//   Input channel in_valid/in_stall carries operation, index and value; a transaction
//   is taken when in_valid is high and in_stall low. Output channel out_valid/out_stall
//   carries read_value, found, accepted, full_drop and list_length, one result per request.
//   Entries sit in one RAM; an insert or delete moves the later entries one place through
//   a single pointer adder, one RAM read then one RAM write per moved entry.
// Requests: a new request is taken the cycle after the previous result enters the output
//   register; in_stall is high while a request is worked on.
// Reset: count goes to zero, the list is empty; RAM contents are not cleared and are
//   never read before being written.
// Stall: the output register holds its result while out_stall is high; one finished
//   result may wait there while the next request is worked on, and the sequencer waits
//   in its final state until the register is free.
module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ilid_pkg::OP_W-1:0]           operation,
    input  logic signed [ilid_pkg::IDX_W-1:0]   index,
    input  logic signed [ilid_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ilid_pkg::DATA_W-1:0]  read_value,
    output logic                                found,
    output logic                                accepted,
    output logic                                full_drop,
    output logic [ilid_pkg::LEN_W-1:0]          list_length
);

    import ilid_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    res_t              res;
    logic              res_valid;
    logic              res_take;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .index     (index),
        .value     (value),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ilid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_reg.read_value;
    assign found       = out_reg.found;
    assign accepted    = out_reg.accepted;
    assign full_drop   = out_reg.full_drop;
    assign list_length = out_reg.list_length;

endmodule

/* test/indexed_list_insert_delete_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list block against a list predictor.
module indexed_list_insert_delete_tb;

    import ilid_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [IDX_W-1:0]  idx;
        logic signed [DATA_W-1:0] val;
    } list_req_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          operation = '0;
    logic signed [IDX_W-1:0]  index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic                     accepted;
    logic                     full_drop;
    logic [LEN_W-1:0]         list_length;

    list_req_t request_q[$];
    res_t      expected_results[$];
    list_req_t cur_req;

    logic [DATA_W-1:0] model_mem [CAP];
    int                model_len = 0;
    int                gen_len = 0;

    int   src_gap = 0;
    int   snk_gap = 0;
    int   accept_cnt = 0;
    int   mismatch_cnt = 0;
    logic idle_on = 1'b1;
    logic sink_hold = 1'b0;

    indexed_list_insert_delete #(
        .CAPACITY(CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .index(index),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_value(read_value),
        .found(found),
        .accepted(accepted),
        .full_drop(full_drop),
        .list_length(list_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_t apply_list_op(list_req_t r);
        res_t res;
        int   idx;
        int   pos;
        bit   ok;
        res = '0;
        idx = int'(r.idx);
        case (r.op)
            OP_READ:
            begin
                if (idx >= 0 && idx < model_len)
                begin
                    res.read_value = model_mem[idx];
                    res.found = 1'b1;
                end
                else
                    res.read_value = '1;
            end
            OP_FRONT, OP_BACK, OP_AT:
            begin
                ok = 1'b1;
                pos = 0;
                if (r.op == OP_BACK)
                    pos = model_len;
                else if (r.op == OP_AT)
                begin
                    if (idx > model_len)
                        ok = 1'b0;
                    else if (idx > 0)
                        pos = idx;
                end
                if (ok)
                begin
                    if (model_len >= CAP)
                        res.full_drop = 1'b1;
                    else
                    begin
                        for (int i = model_len; i > pos; i--)
                            model_mem[i] = model_mem[i - 1];
                        model_mem[pos] = r.val;
                        model_len++;
                        res.accepted = 1'b1;
                    end
                end
            end
            OP_DELETE:
            begin
                if (idx >= 0 && idx < model_len)
                begin
                    for (int i = idx; i + 1 < model_len; i++)
                        model_mem[i] = model_mem[i + 1];
                    model_len--;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.list_length = model_len[LEN_W-1:0];
        return res;
    endfunction

    // queue a request and keep a running length so later indexes can aim at live positions
    task automatic add_req(logic [OP_W-1:0] op, int idx, logic [DATA_W-1:0] val);
        list_req_t r;
        r.op = op;
        r.idx = idx[IDX_W-1:0];
        r.val = val;
        request_q.push_back(r);
        case (op)
            OP_FRONT, OP_BACK:
                if (gen_len < CAP)
                    gen_len++;
            OP_AT:
                if (idx <= gen_len && gen_len < CAP)
                    gen_len++;
            OP_DELETE:
                if (idx >= 0 && idx < gen_len)
                    gen_len--;
            default:
            begin
            end
        endcase
    endtask

    task automatic add_random(int del_w);
        int                      r;
        int                      idx;
        logic signed [IDX_W-1:0] raw;
        logic [OP_W-1:0]         op;
        bit                      ins;
        r = $urandom_range(0, 99);
        raw = IDX_W'($urandom);
        if (r < 4)
            op = OP_DELETE + 3'($urandom_range(1, 3));
        else if (r < 4 + del_w)
            op = OP_DELETE;
        else
        begin
            case ($urandom_range(0, 3))
                0: op = OP_READ;
                1: op = OP_FRONT;
                2: op = OP_BACK;
                default: op = OP_AT;
            endcase
        end
        ins = (op == OP_AT);
        case ($urandom_range(0, 9))
            0: idx = int'(raw);
            1: idx = ins ? gen_len + 1 : gen_len;
            2: idx = -1;
            default:
            begin
                if (ins)
                    idx = $urandom_range(0, gen_len);
                else if (gen_len == 0)
                    idx = 0;
                else
                    idx = $urandom_range(0, gen_len - 1);
            end
        endcase
        add_req(op, idx, $urandom);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_list_op(cur_req));
                accept_cnt <= accept_cnt + 1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 12);
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    cur_req = request_q.pop_front();
                    operation <= cur_req.op;
                    index <= cur_req.idx;
                    value <= cur_req.val;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            idle_on <= (request_q.size() > 80);
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected transaction rd=%0d len=%0d", $realtime,
                                 read_value, list_length);
                end
                else
                begin
                    res_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (read_value !== exp_res.read_value || found !== exp_res.found ||
                        accepted !== exp_res.accepted || full_drop !== exp_res.full_drop ||
                        list_length !== exp_res.list_length)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: mismatch exp rd=%0d fnd=%0b acc=%0b drop=%0b len=%0d",
                                     $realtime, $signed(exp_res.read_value), exp_res.found,
                                     exp_res.accepted, exp_res.full_drop, exp_res.list_length,
                                     "  got rd=%0d fnd=%0b acc=%0b drop=%0b len=%0d",
                                     read_value, found, accepted, full_drop, list_length);
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= sink_hold;
                if (idle_on && $urandom_range(0, 9) == 0)
                    snk_gap = $urandom_range(1, 12);
            end
        end
    end

    // long receiver hold so the block backs up into its input
    initial
    begin
        while (accept_cnt < 40)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        #15_000_000;
        $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

    initial
    begin
        // empty list corners
        add_req(OP_READ, 0, 0);
        add_req(OP_DELETE, 0, 0);
        add_req(OP_AT, 1, 32'h1111_1111);
        add_req(OP_AT, 32767, 32'h2222_2222);
        add_req(OP_AT, -32768, 32'h7fff_ffff);
        add_req(OP_FRONT, 0, 32'h8000_0000);
        add_req(OP_BACK, 0, 32'hffff_ffff);
        add_req(OP_BACK, 0, 32'h0000_0000);
        add_req(OP_AT, gen_len, 32'h0001_e240);
        add_req(OP_AT, 2, 32'h5a5a_a5a5);
        add_req(OP_READ, 0, 0);
        add_req(OP_READ, gen_len - 1, 0);
        add_req(OP_READ, gen_len, 0);
        add_req(OP_READ, -1, 0);
        add_req(OP_READ, 32767, 0);
        add_req(OP_READ, -32768, 0);
        add_req(OP_DELETE + 3'd1, 5, 32'hdead_beef);
        add_req(OP_DELETE + 3'd2, -7, 32'h1234_5678);
        add_req(OP_DELETE + 3'd3, 0, 32'hffff_ffff);
        add_req(OP_DELETE, -1, 0);
        add_req(OP_DELETE, 32767, 0);
        add_req(OP_DELETE, 0, 0);
        add_req(OP_DELETE, gen_len - 1, 0);
        add_req(OP_DELETE, 1, 0);
        add_req(OP_READ, 0, 0);

        repeat (120) add_random(15);

        // fill to capacity, mostly cheap appends
        while (gen_len < CAP)
        begin
            case ($urandom_range(0, 9))
                0: add_req(OP_FRONT, $urandom, $urandom);
                1, 2: add_req(OP_AT, $urandom_range(0, gen_len), $urandom);
                default: add_req(OP_BACK, $urandom, $urandom);
            endcase
        end
        add_req(OP_FRONT, 0, $urandom);
        add_req(OP_BACK, 0, $urandom);
        add_req(OP_AT, 0, $urandom);
        add_req(OP_AT, CAP, $urandom);
        add_req(OP_AT, CAP + 1, $urandom);
        add_req(OP_AT, -5, $urandom);
        add_req(OP_READ, 0, 0);
        add_req(OP_READ, CAP - 1, 0);
        add_req(OP_READ, CAP, 0);
        add_req(OP_DELETE, CAP, 0);
        add_req(OP_DELETE, CAP - 1, 0);
        add_req(OP_BACK, 0, $urandom);
        add_req(OP_BACK, 0, $urandom);
        add_req(OP_DELETE, 0, 0);
        add_req(OP_AT, CAP - 1, $urandom);
        add_req(OP_FRONT, 0, $urandom);
        repeat (10) add_random(10);

        repeat (100) add_random(55);
        repeat (60) add_random(20);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("** indexed_list_insert_delete: PASSED **");
        else
            $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ilid_pkg.sv
rtl/core/ilid_ram.sv
rtl/core/ilid_ctrl.sv
rtl/core/indexed_list_insert_delete.sv
test/indexed_list_insert_delete_tb.sv
